FILE: hw/rtl/etok_pkg.sv
package etok_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUMBER,
        MODE_IDENT,
        MODE_COMMENT,
        MODE_RATE
    } mode_t;

    typedef enum logic [2:0] {
        KIND_LIT  = 3'd0,
        KIND_ID   = 3'd1,
        KIND_OP   = 3'd2,
        KIND_RATE = 3'd3,
        KIND_END  = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t       token_kind;
        logic [31:0] number_value;
        logic [3:0]  op_code;
        logic [63:0] id_text;
        logic [3:0]  id_length;
        logic        last_result;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    localparam logic [31:0] RATE_RESET = 32'd8000;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_MUL   = 4'd2;
    localparam logic [3:0] OP_DIV   = 4'd3;
    localparam logic [3:0] OP_MOD   = 4'd4;
    localparam logic [3:0] OP_AND   = 4'd5;
    localparam logic [3:0] OP_OR    = 4'd6;
    localparam logic [3:0] OP_XOR   = 4'd7;
    localparam logic [3:0] OP_NOT   = 4'd8;
    localparam logic [3:0] OP_AT    = 4'd9;
    localparam logic [3:0] OP_LT    = 4'd10;
    localparam logic [3:0] OP_GT    = 4'd11;
    localparam logic [3:0] OP_EQ    = 4'd12;
    localparam logic [3:0] OP_UNDER = 4'd13;
    localparam logic [3:0] OP_COLON = 4'd14;
    localparam logic [3:0] OP_QUEST = 4'd15;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 104;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    // {hit, code}
    function automatic logic [4:0] op_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        unique case (b)
            "+":     r = {1'b1, OP_ADD};
            "-":     r = {1'b1, OP_SUB};
            "*":     r = {1'b1, OP_MUL};
            "/":     r = {1'b1, OP_DIV};
            "%":     r = {1'b1, OP_MOD};
            "&":     r = {1'b1, OP_AND};
            "|":     r = {1'b1, OP_OR};
            "^":     r = {1'b1, OP_XOR};
            "~":     r = {1'b1, OP_NOT};
            "@":     r = {1'b1, OP_AT};
            "<":     r = {1'b1, OP_LT};
            ">":     r = {1'b1, OP_GT};
            "=":     r = {1'b1, OP_EQ};
            "_":     r = {1'b1, OP_UNDER};
            ":":     r = {1'b1, OP_COLON};
            "?":     r = {1'b1, OP_QUEST};
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/etok_core.sv
module etok_core #(
    parameter int LIT_WIDTH = 32,
    parameter int ID_LEN    = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [7:0]         in_byte,
    input  logic               in_end,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_data,
    output etok_pkg::push_t    push
);

    localparam int ACC_W = (LIT_WIDTH > 32) ? LIT_WIDTH : 32;
    localparam logic [ACC_W-1:0] LIT_MASK  = {ACC_W{1'b1}} >> (ACC_W - LIT_WIDTH);
    localparam logic [ACC_W-1:0] RATE_MASK = ACC_W'(32'hFFFF_FFFF);

    etok_pkg::mode_t   mode_reg, mode_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [63:0]       name_reg, name_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [31:0]       cur_reg, cur_next;
    logic              set_reg, set_next;
    logic [31:0]       dflt_reg, dflt_next;

    logic              dig, let_c;
    logic [3:0]        dig_val;
    logic [ACC_W-1:0]  acc_step;
    logic [4:0]        op_hit;
    logic              do_fin, do_begin;
    logic              fin_hit, beg_hit;
    etok_pkg::result_t fin_tok, beg_tok;

    assign dig      = etok_pkg::is_digit(in_byte);
    assign let_c    = etok_pkg::is_letter(in_byte);
    assign dig_val  = 4'(in_byte - etok_pkg::CH_ZERO);
    assign acc_step = (acc_reg << 3) + (acc_reg << 1) + ACC_W'(dig_val);
    assign op_hit   = etok_pkg::op_decode(in_byte);

    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        name_next = name_reg;
        cnt_next  = cnt_reg;
        cur_next  = cur_reg;
        set_next  = set_reg;
        dflt_next = dflt_reg;
        do_fin    = 1'b0;
        do_begin  = 1'b0;
        fin_hit   = 1'b0;
        beg_hit   = 1'b0;
        fin_tok   = '0;
        beg_tok   = '0;

        if (in_valid)
        begin
            if (in_end)
            begin
                do_fin = 1'b1;
            end
            else
            begin
                unique case (mode_reg)
                    etok_pkg::MODE_COMMENT:
                    begin
                        if (in_byte == etok_pkg::CH_NL)
                        begin
                            mode_next = etok_pkg::MODE_IDLE;
                        end
                    end
                    etok_pkg::MODE_NUMBER:
                    begin
                        if (dig)
                        begin
                            acc_next = acc_step & LIT_MASK;
                        end
                        else
                        begin
                            do_fin   = 1'b1;
                            do_begin = 1'b1;
                        end
                    end
                    etok_pkg::MODE_RATE:
                    begin
                        if (dig)
                        begin
                            acc_next = acc_step & RATE_MASK;
                        end
                        else
                        begin
                            do_fin   = 1'b1;
                            do_begin = 1'b1;
                        end
                    end
                    etok_pkg::MODE_IDENT:
                    begin
                        if ((dig || let_c) && (cnt_reg < 4'(ID_LEN)))
                        begin
                            name_next[{cnt_reg[2:0], 3'b000} +: 8] = in_byte;
                            cnt_next = cnt_reg + 4'd1;
                        end
                        else
                        begin
                            do_fin   = 1'b1;
                            do_begin = 1'b1;
                        end
                    end
                    default:
                    begin
                        do_begin = 1'b1;
                    end
                endcase
            end
        end

        // flush pending token
        if (do_fin)
        begin
            case (mode_reg)
                etok_pkg::MODE_NUMBER:
                begin
                    fin_hit                  = 1'b1;
                    fin_tok.token_kind       = etok_pkg::KIND_LIT;
                    fin_tok.number_value     = acc_reg[31:0];
                end
                etok_pkg::MODE_IDENT:
                begin
                    fin_hit                  = 1'b1;
                    fin_tok.token_kind       = etok_pkg::KIND_ID;
                    fin_tok.id_text          = name_reg;
                    fin_tok.id_length        = cnt_reg;
                end
                etok_pkg::MODE_RATE:
                begin
                    fin_hit                  = 1'b1;
                    cur_next                 = acc_reg[31:0];
                    set_next                 = 1'b1;
                    fin_tok.token_kind       = etok_pkg::KIND_RATE;
                    fin_tok.number_value     = acc_reg[31:0];
                end
                default:
                begin
                    fin_hit = 1'b0;
                end
            endcase
            mode_next = etok_pkg::MODE_IDLE;
            acc_next  = '0;
            name_next = '0;
            cnt_next  = '0;
        end

        // start a new token from this byte
        if (do_begin)
        begin
            if (dig)
            begin
                mode_next = etok_pkg::MODE_NUMBER;
                acc_next  = ACC_W'(dig_val);
            end
            else if (let_c)
            begin
                mode_next = etok_pkg::MODE_IDENT;
                name_next = 64'(in_byte);
                cnt_next  = 4'd1;
            end
            else if (in_byte == etok_pkg::CH_HASH)
            begin
                mode_next = etok_pkg::MODE_COMMENT;
            end
            else if (in_byte == etok_pkg::CH_BSLASH)
            begin
                mode_next = etok_pkg::MODE_RATE;
                acc_next  = '0;
            end
            else
            begin
                beg_hit            = op_hit[4];
                beg_tok.token_kind = etok_pkg::KIND_OP;
                beg_tok.op_code    = op_hit[3:0];
            end
        end

        if (in_valid && in_end)
        begin
            beg_hit              = 1'b1;
            beg_tok.token_kind   = etok_pkg::KIND_END;
            beg_tok.number_value = cur_next;
            cur_next             = dflt_reg;
            set_next             = 1'b0;
        end

        if (cfg_we)
        begin
            dflt_next = cfg_data;
            if (!set_next)
            begin
                cur_next = cfg_data;
            end
        end
    end

    always_comb
    begin
        push = '0;
        if (fin_hit && beg_hit)
        begin
            push.count              = 2'd2;
            push.first              = fin_tok;
            push.second             = beg_tok;
            push.second.last_result = 1'b1;
        end
        else if (fin_hit)
        begin
            push.count             = 2'd1;
            push.first             = fin_tok;
            push.first.last_result = 1'b1;
        end
        else if (beg_hit)
        begin
            push.count             = 2'd1;
            push.first             = beg_tok;
            push.first.last_result = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= etok_pkg::MODE_IDLE;
            acc_reg  <= '0;
            name_reg <= '0;
            cnt_reg  <= '0;
            cur_reg  <= etok_pkg::RATE_RESET;
            set_reg  <= 1'b0;
            dflt_reg <= etok_pkg::RATE_RESET;
        end
        else
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            name_reg <= name_next;
            cnt_reg  <= cnt_next;
            cur_reg  <= cur_next;
            set_reg  <= set_next;
            dflt_reg <= dflt_next;
        end
    end

endmodule

FILE: hw/rtl/etok_fifo.sv
module etok_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  etok_pkg::push_t   push,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output etok_pkg::result_t out_entry
);

    etok_pkg::result_t                   mem_reg [etok_pkg::FIFO_DEPTH];
    logic [etok_pkg::FIFO_PTR_W-1:0]     wptr_reg, wptr_next;
    logic [etok_pkg::FIFO_PTR_W-1:0]     rptr_reg, rptr_next;
    logic [etok_pkg::FIFO_CNT_W-1:0]     count_reg, count_next;
    logic [etok_pkg::FIFO_PTR_W-1:0]     wptr_plus1;
    logic                                pop;

    assign in_ready   = count_reg <= etok_pkg::FIFO_CNT_W'(etok_pkg::FIFO_DEPTH - 2);
    assign out_valid  = count_reg != '0;
    assign out_entry  = mem_reg[rptr_reg];
    assign pop        = out_valid && out_ready;
    assign wptr_plus1 = wptr_reg + etok_pkg::FIFO_PTR_W'(1);

    always_comb
    begin
        wptr_next  = wptr_reg + etok_pkg::FIFO_PTR_W'(push.count);
        rptr_next  = pop ? rptr_reg + etok_pkg::FIFO_PTR_W'(1) : rptr_reg;
        count_next = count_reg + etok_pkg::FIFO_CNT_W'(push.count)
                     - etok_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wptr_plus1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: hw/rtl/expression_tokenizer.sv
// Expression tokenizer: turns a byte stream of program text into tokens.
// Input channel s_*: one source byte per transfer in s_tdata[7:0]; s_tlast
// marks end of input, in which case the byte is ignored and the pending
// token is flushed, followed by an end token carrying the sample rate.
// Output channel m_*: one token per transfer; m_tuser carries the token kind;
// m_tlast is high on the last token caused by an input byte.
// A byte gives zero, one or two tokens.
// Configuration channel cfg_*: writes the default sample rate; always ready.
// A token enters the queue registers when its byte is accepted and reaches
// m_* once earlier tokens drain. Throughput: one byte per cycle while each
// byte yields at most one token and m_tready is high; a byte yielding two
// tokens needs two transfers out. Limit: one output port, four-entry queue.
// s_tready is high while the queue has room for two tokens, so it does not
// depend on m_tready in the same cycle; a stalled receiver fills the queue
// and then holds off the source. Stalled output data stays stable.
// Reset: scanner idle, queue empty, default and current rate 8000.
module expression_tokenizer #(
    parameter int LIT_WIDTH = 32,
    parameter int ID_LEN    = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [etok_pkg::IN_DATA_W-1:0]   s_tdata,  // source_byte
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // number_value, op_code, id_text, id_length
    output logic [etok_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic [2:0]                       m_tuser,  // token_kind
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [31:0]                      cfg_data
);

    etok_pkg::push_t   push;
    etok_pkg::result_t head;
    logic              accept;

    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    etok_core #(
        .LIT_WIDTH (LIT_WIDTH),
        .ID_LEN    (ID_LEN)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .in_byte  (s_tdata[7:0]),
        .in_end   (s_tlast),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .push     (push)
    );

    etok_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_entry (head)
    );

    assign m_tdata = {head.id_length, head.id_text, head.op_code, head.number_value};
    assign m_tuser = head.token_kind;
    assign m_tlast = head.last_result;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import etok_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 200;
    localparam int NAME_MAX       = 8;
    localparam int RANDOM_BYTES   = 1100;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;  // source_byte
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // number_value, op_code, id_text, id_length
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [2:0]            m_tuser;  // token_kind
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [31:0]           cfg_data  = '0;

    // scanner state as the predictor sees it
    mode_t       scan_mode   = MODE_IDLE;
    logic [31:0] lit_accum   = '0;
    logic [63:0] name_chars  = '0;
    int          name_len    = 0;
    logic [31:0] default_rate = RATE_RESET;
    logic [31:0] active_rate  = RATE_RESET;
    bit          rate_given  = 1'b0;

    result_t     step_tokens[$];
    result_t     tokens_due[$];

    logic [7:0]  op_chars [16] = '{"+", "-", "*", "/", "%", "&", "|", "^",
                                   "~", "@", "<", ">", "=", "_", ":", "?"};

    bit          gaps_on     = 1'b0;
    int          sink_gap    = 0;
    int          sink_hold   = 0;
    int          bytes_sent  = 0;
    int          mismatches  = 0;
    int          quiet_cycles = 0;

    expression_tokenizer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic bit is_dec(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic bit is_alpha(input logic [7:0] b);
        return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
    endfunction

    function automatic void add_token(input kind_t kind, input logic [31:0] num,
                                      input logic [3:0] op, input logic [63:0] text,
                                      input logic [3:0] len);
        result_t t;
        t.token_kind   = kind;
        t.number_value = num;
        t.op_code      = op;
        t.id_text      = text;
        t.id_length    = len;
        t.last_result  = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void flush_token();
        case (scan_mode)
            MODE_NUMBER: add_token(KIND_LIT, lit_accum, '0, '0, '0);
            MODE_IDENT:  add_token(KIND_ID, '0, '0, name_chars, 4'(name_len));
            MODE_RATE:
            begin
                active_rate = lit_accum;
                rate_given  = 1'b1;
                add_token(KIND_RATE, active_rate, '0, '0, '0);
            end
            default: ;
        endcase
        scan_mode  = MODE_IDLE;
        lit_accum  = '0;
        name_chars = '0;
        name_len   = 0;
    endfunction

    function automatic void start_token(input logic [7:0] b);
        int k;
        if (is_dec(b))
        begin
            scan_mode = MODE_NUMBER;
            lit_accum = 32'(b - CH_ZERO);
        end
        else if (is_alpha(b))
        begin
            scan_mode  = MODE_IDENT;
            name_chars = 64'(b);
            name_len   = 1;
        end
        else if (b == CH_HASH)
            scan_mode = MODE_COMMENT;
        else if (b == CH_BSLASH)
        begin
            scan_mode = MODE_RATE;
            lit_accum = '0;
        end
        else
        begin
            for (k = 0; k < 16; k++)
            begin
                if (b == op_chars[4'(k)])
                    add_token(KIND_OP, '0, 4'(k), '0, '0);
            end
        end
    endfunction

    function automatic void tokenize_byte(input logic [7:0] b, input logic eoi);
        int i;
        step_tokens.delete();
        if (eoi)
        begin
            flush_token();
            add_token(KIND_END, active_rate, '0, '0, '0);
            active_rate = default_rate;
            rate_given  = 1'b0;
        end
        else
        begin
            case (scan_mode)
                MODE_COMMENT:
                    if (b == CH_NL)
                        scan_mode = MODE_IDLE;
                MODE_NUMBER, MODE_RATE:
                    if (is_dec(b))
                        lit_accum = lit_accum * 32'd10 + 32'(b - CH_ZERO);
                    else
                    begin
                        flush_token();
                        start_token(b);
                    end
                MODE_IDENT:
                    if ((is_alpha(b) || is_dec(b)) && name_len < NAME_MAX)
                    begin
                        name_chars = name_chars | (64'(b) << (8 * name_len));
                        name_len++;
                    end
                    else
                    begin
                        flush_token();
                        start_token(b);
                    end
                default:
                    start_token(b);
            endcase
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last_result = 1'b1;
        for (i = 0; i < step_tokens.size(); i++)
            tokens_due.push_back(step_tokens[i]);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic check_token(input logic [2:0] kind, input logic [OUT_DATA_W-1:0] data,
                               input logic last);
        result_t want;
        if (tokens_due.size() == 0)
        begin
            report_mismatch("token with none due", data[63:0], '0);
            return;
        end
        want = tokens_due.pop_front();
        if (kind !== want.token_kind)
            report_mismatch("token_kind", 64'(kind), 64'(want.token_kind));
        if (data[31:0] !== want.number_value)
            report_mismatch("number_value", 64'(data[31:0]), 64'(want.number_value));
        if (data[35:32] !== want.op_code)
            report_mismatch("op_code", 64'(data[35:32]), 64'(want.op_code));
        if (data[99:36] !== want.id_text)
            report_mismatch("id_text", data[99:36], want.id_text);
        if (data[103:100] !== want.id_length)
            report_mismatch("id_length", 64'(data[103:100]), 64'(want.id_length));
        if (last !== want.last_result)
            report_mismatch("last_result", 64'(last), 64'(want.last_result));
    endtask

    // token sink: check each transfer, then draw the next stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                check_token(m_tuser, m_tdata, m_tlast);
                sink_gap = gaps_on ? $urandom_range(0, 11) : 0;
            end
            if (sink_hold > 0)
            begin
                sink_hold--;
                m_tready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eoi);
        int gap;
        gap = gaps_on ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= b;
        s_tlast  <= eoi;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        tokenize_byte(b, eoi);
        bytes_sent++;
    endtask

    task automatic send_text(input string text);
        int i;
        for (i = 0; i < text.len(); i++)
            send_byte(text[i], 1'b0);
    endtask

    task automatic send_end();
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tokens_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_rate(input logic [31:0] value);
        settle();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        default_rate = value;
        if (!rate_given)
            active_rate = value;
    endtask

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'(8'h61 + r) : 8'(8'h41 + r - 26);
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'(CH_ZERO + $urandom_range(0, 9));
    endfunction

    task automatic test_reset_rate();
        send_end();
    endtask

    task automatic test_operators();
        send_text("+-*/%&|^~@<>=_:?");
        send_end();
    endtask

    task automatic test_literals();
        send_text("0 4294967296*99999999999");
        send_end();
    endtask

    task automatic test_identifiers();
        send_text("abcdefghiZ9q1 ABCDEFGH7 x7");
        send_end();
    endtask

    task automatic test_comment_and_rate();
        send_text("#a+\n\\44100;\\+");
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_end();
        send_text("#zz");
        send_end();
    endtask

    task automatic test_config();
        write_rate(32'd0);
        send_end();
        write_rate(32'hFFFF_FFFF);
        send_end();
        send_text("\\5 ");
        write_rate(32'd123);
        send_end();
        send_end();
        write_rate(RATE_RESET);
    endtask

    task automatic test_backpressure();
        settle();
        gaps_on   = 1'b0;
        sink_hold = HOLD_CYCLES;
        repeat (24) send_text("x+");
        send_end();
        settle();
    endtask

    task automatic send_program();
        int pieces;
        int len;
        int pick;
        pieces = $urandom_range(1, 12);
        repeat (pieces)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 5)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 14)
                                                  : $urandom_range(1, 4);
                repeat (len) send_byte(rand_digit(), 1'b0);
            end
            else if (pick < 10)
            begin
                len = $urandom_range(1, 12);
                send_byte(rand_letter(), 1'b0);
                repeat (len - 1)
                    send_byte($urandom_range(0, 3) == 0 ? rand_digit() : rand_letter(), 1'b0);
            end
            else if (pick < 14)
                send_byte(op_chars[4'($urandom_range(0, 15))], 1'b0);
            else if (pick < 16)
                send_byte($urandom_range(0, 1) ? 8'h20 : CH_NL, 1'b0);
            else if (pick < 17)
            begin
                send_byte(CH_HASH, 1'b0);
                repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(0, 255)), 1'b0);
                if ($urandom_range(0, 3) != 0)
                    send_byte(CH_NL, 1'b0);
            end
            else if (pick < 19)
            begin
                send_byte(CH_BSLASH, 1'b0);
                repeat ($urandom_range(0, 10)) send_byte(rand_digit(), 1'b0);
            end
            else
                send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        send_end();
    endtask

    task automatic test_random();
        int programs;
        int pick;
        programs = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            gaps_on = ($urandom_range(0, 2) != 0);
            send_program();
            programs++;
            if (programs % 8 == 0)
            begin
                pick = $urandom_range(0, 3);
                if (pick == 0)
                    write_rate(32'd0);
                else if (pick == 1)
                    write_rate(32'hFFFF_FFFF);
                else
                    write_rate($urandom);
            end
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_rate();
        test_operators();
        test_literals();
        test_identifiers();
        test_comment_and_rate();
        test_config();
        test_backpressure();
        gaps_on = 1'b1;
        test_operators();
        test_random();
        settle();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
